/* hdl/brim_pkg.sv */
// Shared widths, register indexes and types for the bond replica index remap.
// No dependencies; used by every module of the block.
package brim_pkg;

	localparam int MAX_COPIES_PER_AXIS = 16;
	localparam int INDEX_BITS          = 32;

	localparam int CNT_W   = 5;
	localparam int COPY_W  = 4;
	localparam int SHIFT_W = 8;
	localparam int NSH_W   = 9;
	localparam int PIDX_W  = 32;
	localparam int OIDX_W  = 44;
	localparam int CFG_W   = 32;
	localparam int NUMA_W  = 10;
	localparam int NUM_W   = 15;
	localparam int DVD_W   = 12;
	localparam int STEP_N  = 4;

	localparam logic [PIDX_W-1:0] IDX_MASK = (INDEX_BITS >= PIDX_W) ? {PIDX_W{1'b1}} :
		PIDX_W'((64'd1 << INDEX_BITS) - 64'd1);

	typedef logic [CNT_W-1:0] cnt_t;

	typedef enum logic [2:0] {
		REG_COPIES_X   = 3'd0,
		REG_COPIES_Y   = 3'd1,
		REG_COPIES_Z   = 3'd2,
		REG_PPC        = 3'd3,
		REG_ADJUST_BOX = 3'd4,
		REG_HAS_SHIFTS = 3'd5
	} reg_idx_t;

	typedef struct packed {
		cnt_t n;
		logic adjust;
		logic use_shift;
	} axis_cfg_t;

endpackage

/* hdl/brim_axis.sv */
// One axis: target copy (wrapped coordinate) and new periodic shift.
// Floor division by the copy count as a 3-stage restoring divider. Uses brim_pkg.
module brim_axis (
	input  logic                                   clk,
	input  logic [brim_pkg::COPY_W-1:0]            copy,
	input  logic signed [brim_pkg::SHIFT_W-1:0]    shift,
	input  brim_pkg::axis_cfg_t                    cfg,
	output brim_pkg::cnt_t                         target_s3,
	output logic signed [brim_pkg::NSH_W-1:0]      new_shift_s4
);

	localparam int CW = brim_pkg::CNT_W;
	localparam int SN = brim_pkg::STEP_N;
	localparam int DW = brim_pkg::DVD_W;

	function automatic logic [SN+CW-1:0] div_steps(input logic [CW-1:0] rem_in,
		input logic [SN-1:0] bits, input logic [CW-1:0] n);
		logic [CW-1:0] rem;
		logic [CW:0]   trial;
		logic [SN-1:0] quo;
		rem = rem_in;
		quo = '0;
		for (int i = SN - 1; i >= 0; i--) begin
			trial = {rem, bits[i]};
			if (trial >= {1'b0, n}) begin
				trial  = trial - {1'b0, n};
				quo[i] = 1'b1;
			end
			rem = trial[CW-1:0];
		end
		return {quo, rem};
	endfunction

	logic signed [brim_pkg::SHIFT_W-1:0] s_eff;
	logic [brim_pkg::NSH_W-1:0]          t;
	logic [DW-1:0]                       dvd;
	logic [SN+CW-1:0]                    st1, st2, st3;

	logic [brim_pkg::NSH_W-1:0] t_s1, t_s2, t_s3;
	logic [CW-1:0]              rem_s1, rem_s2, rem_s3;
	logic [2*SN-1:0]            dvd_s1;
	logic [SN-1:0]              dvd_s2;
	logic [SN-1:0]              quo_s1;
	logic [2*SN-1:0]            quo_s2;
	logic [DW-1:0]              quo_s3;
	logic [DW-1:0]              q_adj;
	logic [brim_pkg::NSH_W-1:0] t_minus_r;

	always_comb begin
		s_eff = cfg.use_shift ? shift : '0;
		t     = {{(brim_pkg::NSH_W-brim_pkg::COPY_W){1'b0}}, copy} +
			{{(brim_pkg::NSH_W-brim_pkg::SHIFT_W){s_eff[brim_pkg::SHIFT_W-1]}}, s_eff};
		// bias by 128*n so the dividend is never negative
		dvd   = {{(DW-brim_pkg::NSH_W){t[brim_pkg::NSH_W-1]}}, t} + {cfg.n, 7'b0};
		st1   = div_steps('0, dvd[DW-1 -: SN], cfg.n);
		st2   = div_steps(rem_s1, dvd_s1[2*SN-1 -: SN], cfg.n);
		st3   = div_steps(rem_s2, dvd_s2, cfg.n);
	end

	always_ff @(posedge clk) begin
		t_s1   <= t;
		dvd_s1 <= dvd[2*SN-1:0];
		quo_s1 <= st1[SN+CW-1:CW];
		rem_s1 <= st1[CW-1:0];

		t_s2   <= t_s1;
		dvd_s2 <= dvd_s1[SN-1:0];
		quo_s2 <= {quo_s1, st2[SN+CW-1:CW]};
		rem_s2 <= st2[CW-1:0];

		t_s3   <= t_s2;
		quo_s3 <= {quo_s2, st3[SN+CW-1:CW]};
		rem_s3 <= st3[CW-1:0];
	end

	always_comb begin
		q_adj     = quo_s3 - DW'(128);
		t_minus_r = t_s3 - {{(brim_pkg::NSH_W-CW){1'b0}}, rem_s3};
	end

	always_ff @(posedge clk) begin
		new_shift_s4 <= cfg.adjust ? q_adj[brim_pkg::NSH_W-1:0] : t_minus_r;
	end

	assign target_s3 = rem_s3;

endmodule

/* hdl/brim_offset.sv */
// Particle index offset: index + copy number * particles per copy.
// Two stages (multiply, then add), result wraps to the output width. Uses brim_pkg.
module brim_offset (
	input  logic                          clk,
	input  logic [brim_pkg::NUM_W-1:0]    num,
	input  logic [brim_pkg::PIDX_W-1:0]   ppc,
	input  logic [brim_pkg::PIDX_W-1:0]   idx,
	output logic [brim_pkg::OIDX_W-1:0]   sum_s2
);

	logic [brim_pkg::OIDX_W-1:0] prod_s1;
	logic [brim_pkg::PIDX_W-1:0] idx_s1;

	always_ff @(posedge clk) begin
		prod_s1 <= brim_pkg::OIDX_W'(num) * brim_pkg::OIDX_W'(ppc);
		idx_s1  <= idx;
		sum_s2  <= prod_s1 + brim_pkg::OIDX_W'(idx_s1);
	end

endmodule

/* hdl/bond_replica_index_remap.sv */
// Bond replica index remap, top level: configuration registers, valid chain,
// copy-number arithmetic. Uses brim_pkg, brim_axis and brim_offset.
//
// Usage:
//   A request is taken at each rising edge where start is high and busy is low;
//   busy stays low, so one bond may enter every cycle. The request carries the
//   replica's copy coordinates, both particle indices and the bond's shift.
//   Each result appears for one cycle, with done high; results leave in
//   request order at up to one per cycle. The result path runs through the
//   three-stage count divider, then the second particle's copy-number
//   multiply-add and its stride multiply and add. The receiver cannot stall;
//   nothing in the pipeline waits on it. Registers are written through cfg_we,
//   cfg_index and cfg_data, one per cycle; the user must do so only while no
//   request is in flight, which the block does not enforce. Unknown indexes are
//   ignored. Reset (arst_n low) empties the pipeline and restores the register
//   defaults: one copy per axis, stride one, box adjust on, shifts off.
module bond_replica_index_remap (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [2:0]                           cfg_index,
	input  logic [brim_pkg::CFG_W-1:0]           cfg_data,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [brim_pkg::COPY_W-1:0]          copy_x,
	input  logic [brim_pkg::COPY_W-1:0]          copy_y,
	input  logic [brim_pkg::COPY_W-1:0]          copy_z,
	input  logic [brim_pkg::PIDX_W-1:0]          first_particle,
	input  logic [brim_pkg::PIDX_W-1:0]          second_particle,
	input  logic signed [brim_pkg::SHIFT_W-1:0]  shift_x,
	input  logic signed [brim_pkg::SHIFT_W-1:0]  shift_y,
	input  logic signed [brim_pkg::SHIFT_W-1:0]  shift_z,
	output logic                                 done,
	output logic [brim_pkg::OIDX_W-1:0]          new_first_particle,
	output logic [brim_pkg::OIDX_W-1:0]          new_second_particle,
	output logic signed [brim_pkg::NSH_W-1:0]    new_shift_x,
	output logic signed [brim_pkg::NSH_W-1:0]    new_shift_y,
	output logic signed [brim_pkg::NSH_W-1:0]    new_shift_z
);

	localparam int CW = brim_pkg::CNT_W;

	function automatic brim_pkg::cnt_t eff_count(input brim_pkg::cnt_t v);
		brim_pkg::cnt_t r;
		r = v;
		if (r == '0)
			r = CW'(1);
		if (32'(r) > 32'(brim_pkg::MAX_COPIES_PER_AXIS))
			r = CW'(brim_pkg::MAX_COPIES_PER_AXIS);
		return r;
	endfunction

	brim_pkg::cnt_t              copies_x_q, copies_y_q, copies_z_q;
	logic [brim_pkg::PIDX_W-1:0] ppc_q;
	logic                        adjust_box_q, has_shifts_q;

	brim_pkg::cnt_t              nx, ny, nz;
	logic [brim_pkg::PIDX_W-1:0] ppc_eff;
	brim_pkg::axis_cfg_t         cfg_x, cfg_y, cfg_z;
	logic                        accept;

	logic                        valid_s1, valid_s2, valid_s3, valid_s4;
	logic                        valid_s5, valid_s6, valid_s7;
	logic [brim_pkg::NUMA_W-1:0] num1a_s1, num2a_s4;
	logic [brim_pkg::COPY_W-1:0] cz_s1;
	logic [brim_pkg::NUM_W-1:0]  num1_s2, num2_s5;
	logic [brim_pkg::PIDX_W-1:0] p1_s1, p1_s2;
	logic [brim_pkg::PIDX_W-1:0] p2_s1, p2_s2, p2_s3, p2_s4, p2_s5;
	brim_pkg::cnt_t              rx_s3, ry_s3, rz_s3, rz_s4;
	logic [brim_pkg::OIDX_W-1:0] first_s4, first_s5, first_s6, first_s7;
	logic [brim_pkg::OIDX_W-1:0] second_s7;
	logic signed [brim_pkg::NSH_W-1:0] shx_s4, shy_s4, shz_s4;
	logic signed [brim_pkg::NSH_W-1:0] shx_s5, shy_s5, shz_s5;
	logic signed [brim_pkg::NSH_W-1:0] shx_s6, shy_s6, shz_s6;
	logic signed [brim_pkg::NSH_W-1:0] shx_s7, shy_s7, shz_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			copies_x_q   <= CW'(1);
			copies_y_q   <= CW'(1);
			copies_z_q   <= CW'(1);
			ppc_q        <= brim_pkg::PIDX_W'(1);
			adjust_box_q <= 1'b1;
			has_shifts_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				brim_pkg::REG_COPIES_X:   copies_x_q   <= cfg_data[CW-1:0];
				brim_pkg::REG_COPIES_Y:   copies_y_q   <= cfg_data[CW-1:0];
				brim_pkg::REG_COPIES_Z:   copies_z_q   <= cfg_data[CW-1:0];
				brim_pkg::REG_PPC:        ppc_q        <= cfg_data[brim_pkg::PIDX_W-1:0];
				brim_pkg::REG_ADJUST_BOX: adjust_box_q <= cfg_data[0];
				brim_pkg::REG_HAS_SHIFTS: has_shifts_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		nx      = eff_count(copies_x_q);
		ny      = eff_count(copies_y_q);
		nz      = eff_count(copies_z_q);
		ppc_eff = ppc_q & brim_pkg::IDX_MASK;
		cfg_x   = '{n: nx, adjust: adjust_box_q, use_shift: has_shifts_q};
		cfg_y   = '{n: ny, adjust: adjust_box_q, use_shift: has_shifts_q};
		cfg_z   = '{n: nz, adjust: adjust_box_q, use_shift: has_shifts_q};
	end

	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
		end
	end

	brim_axis u_axis_x (
		.clk(clk), .copy(copy_x), .shift(shift_x), .cfg(cfg_x),
		.target_s3(rx_s3), .new_shift_s4(shx_s4)
	);

	brim_axis u_axis_y (
		.clk(clk), .copy(copy_y), .shift(shift_y), .cfg(cfg_y),
		.target_s3(ry_s3), .new_shift_s4(shy_s4)
	);

	brim_axis u_axis_z (
		.clk(clk), .copy(copy_z), .shift(shift_z), .cfg(cfg_z),
		.target_s3(rz_s3), .new_shift_s4(shz_s4)
	);

	// source copy number: (cx * ny + cy) * nz + cz
	always_ff @(posedge clk) begin
		num1a_s1 <= brim_pkg::NUMA_W'(copy_x) * brim_pkg::NUMA_W'(ny) +
			brim_pkg::NUMA_W'(copy_y);
		cz_s1    <= copy_z;
		p1_s1    <= first_particle & brim_pkg::IDX_MASK;
		p2_s1    <= second_particle & brim_pkg::IDX_MASK;

		num1_s2  <= brim_pkg::NUM_W'(num1a_s1) * brim_pkg::NUM_W'(nz) +
			brim_pkg::NUM_W'(cz_s1);
		p1_s2    <= p1_s1;
		p2_s2    <= p2_s1;
		p2_s3    <= p2_s2;
	end

	brim_offset u_off_first (
		.clk(clk), .num(num1_s2), .ppc(ppc_eff), .idx(p1_s2), .sum_s2(first_s4)
	);

	// target copy number from the wrapped coordinates
	always_ff @(posedge clk) begin
		num2a_s4 <= brim_pkg::NUMA_W'(rx_s3) * brim_pkg::NUMA_W'(ny) +
			brim_pkg::NUMA_W'(ry_s3);
		rz_s4    <= rz_s3;
		p2_s4    <= p2_s3;

		num2_s5  <= brim_pkg::NUM_W'(num2a_s4) * brim_pkg::NUM_W'(nz) +
			brim_pkg::NUM_W'(rz_s4);
		p2_s5    <= p2_s4;
	end

	brim_offset u_off_second (
		.clk(clk), .num(num2_s5), .ppc(ppc_eff), .idx(p2_s5), .sum_s2(second_s7)
	);

	always_ff @(posedge clk) begin
		first_s5 <= first_s4;
		first_s6 <= first_s5;
		first_s7 <= first_s6;
		shx_s5   <= shx_s4;
		shy_s5   <= shy_s4;
		shz_s5   <= shz_s4;
		shx_s6   <= shx_s5;
		shy_s6   <= shy_s5;
		shz_s6   <= shz_s5;
		shx_s7   <= shx_s6;
		shy_s7   <= shy_s6;
		shz_s7   <= shz_s6;
	end

	assign done                = valid_s7;
	assign new_first_particle  = first_s7;
	assign new_second_particle = second_s7;
	assign new_shift_x         = shx_s7;
	assign new_shift_y         = shy_s7;
	assign new_shift_z         = shz_s7;

endmodule
